FILE: sv/qs_pkg.sv
package qs_pkg;

	localparam int CW        = 36;
	localparam int S_W       = 31;
	localparam int DIV_BITS  = 47;
	localparam int SQ_STEPS  = 31;
	localparam int RAD_W     = 62;
	localparam int SQ_REM_W  = 33;
	localparam int ATAN_MAX  = 24;

	localparam logic [31:0] HALF_PI  = 32'd1686629714;
	localparam logic [31:0] FULL_PI  = 32'd3373259428;
	localparam logic [46:0] RATIO_MAX = 47'h1 << 46;
	localparam logic [16:0] T_ONE    = 17'd65536;

	typedef enum logic [1:0] {
		PATH_FIRST = 2'd0,
		PATH_AVG   = 2'd1,
		PATH_SLERP = 2'd2
	} path_t;

	typedef struct packed {
		logic [63:0]        qa;
		logic [63:0]        qb;
		logic [16:0]        t;
		logic               first;
		logic signed [31:0] c;
	} sq_side_t;

	typedef struct packed {
		logic [63:0]    qa;
		logic [63:0]    qb;
		logic [16:0]    t;
		path_t          path;
		logic [S_W-1:0] s;
	} vec_side_t;

	typedef struct packed {
		logic [63:0] qa;
		logic [63:0] qb;
		path_t       path;
	} rot_side_t;

	typedef struct packed {
		logic [63:0] qa;
		logic [63:0] qb;
		path_t       path;
		logic        ovf;
	} div_side_t;

	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			default: r = 32'd1 << (30 - idx);
		endcase
		return r;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		int i;
		rem  = v;
		root = '0;
		bitv = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bitv > v) bitv = bitv >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (bitv != 64'd0) begin
				if (rem >= root + bitv) begin
					rem  = rem - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return root;
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [31:0] cordic_gain(input int stages);
		logic [63:0] k;
		logic [63:0] d;
		int i;
		k = 64'd1 << 30;
		for (i = 0; i < stages; i++) begin
			d = isqrt64((64'd1 << 60) + ((64'd1 << 60) >> (2 * i)));
			k = udiv64(k << 30, d);
		end
		return k[31:0];
	endfunction

endpackage

FILE: sv/qs_cordic_cell.sv
module qs_cordic_cell #(
	parameter int IDX       = 0,
	parameter bit VECTORING = 1'b0,
	parameter int SIDE_W    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic signed [qs_pkg::CW-1:0]  x_in,
	input  logic signed [qs_pkg::CW-1:0]  y_in,
	input  logic signed [qs_pkg::CW-1:0]  z_in,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          valid_out,
	output logic signed [qs_pkg::CW-1:0]  x_out,
	output logic signed [qs_pkg::CW-1:0]  y_out,
	output logic signed [qs_pkg::CW-1:0]  z_out,
	output logic [SIDE_W-1:0]             side_out
);

	localparam logic signed [qs_pkg::CW-1:0] ATAN_C =
		$signed(qs_pkg::CW'(qs_pkg::atan_q30(IDX)));

	logic signed [qs_pkg::CW-1:0] xs, ys, x_nx, y_nx, z_nx;
	logic                         ccw;
	logic                         valid_s1;
	logic signed [qs_pkg::CW-1:0] x_s1, y_s1, z_s1;
	logic [SIDE_W-1:0]            side_s1;

	always_comb begin
		xs  = x_in >>> IDX;
		ys  = y_in >>> IDX;
		ccw = VECTORING ? y_in[qs_pkg::CW-1] : ~z_in[qs_pkg::CW-1];
		if (ccw) begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - ATAN_C;
		end else begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + ATAN_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_nx;
			y_s1    <= y_nx;
			z_s1    <= z_nx;
			side_s1 <= side_in;
		end
	end

	assign valid_out = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;
	assign side_out  = side_s1;

endmodule

FILE: sv/qs_sqrt_cell.sv
module qs_sqrt_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid_in,
	input  logic [qs_pkg::SQ_REM_W-1:0]      rem_in,
	input  logic [qs_pkg::S_W-1:0]           root_in,
	input  logic [qs_pkg::RAD_W-1:0]         rad_in,
	input  logic [SIDE_W-1:0]                side_in,
	output logic                             valid_out,
	output logic [qs_pkg::SQ_REM_W-1:0]      rem_out,
	output logic [qs_pkg::S_W-1:0]           root_out,
	output logic [qs_pkg::RAD_W-1:0]         rad_out,
	output logic [SIDE_W-1:0]                side_out
);

	logic [qs_pkg::SQ_REM_W+1:0] nr, trial;
	logic                        ge;
	logic                        valid_s1;
	logic [qs_pkg::SQ_REM_W-1:0] rem_s1;
	logic [qs_pkg::S_W-1:0]      root_s1;
	logic [qs_pkg::RAD_W-1:0]    rad_s1;
	logic [SIDE_W-1:0]           side_s1;

	always_comb begin
		nr    = {rem_in, rad_in[qs_pkg::RAD_W-1 -: 2]};
		trial = (qs_pkg::SQ_REM_W+2)'({root_in, 2'b01});
		ge    = nr >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? qs_pkg::SQ_REM_W'(nr - trial) : qs_pkg::SQ_REM_W'(nr);
			root_s1 <= {root_in[qs_pkg::S_W-2:0], ge};
			rad_s1  <= rad_in << 2;
			side_s1 <= side_in;
		end
	end

	assign valid_out = valid_s1;
	assign rem_out   = rem_s1;
	assign root_out  = root_s1;
	assign rad_out   = rad_s1;
	assign side_out  = side_s1;

endmodule

FILE: sv/qs_div_cell.sv
module qs_div_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic [qs_pkg::S_W-1:0]        rem_in,
	input  logic [qs_pkg::S_W-1:0]        den_in,
	input  logic [qs_pkg::DIV_BITS-1:0]   num_in,
	input  logic [qs_pkg::DIV_BITS-1:0]   quo_in,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          valid_out,
	output logic [qs_pkg::S_W-1:0]        rem_out,
	output logic [qs_pkg::S_W-1:0]        den_out,
	output logic [qs_pkg::DIV_BITS-1:0]   num_out,
	output logic [qs_pkg::DIV_BITS-1:0]   quo_out,
	output logic [SIDE_W-1:0]             side_out
);

	logic [qs_pkg::S_W:0]          nr;
	logic                          ge;
	logic                          valid_s1;
	logic [qs_pkg::S_W-1:0]        rem_s1, den_s1;
	logic [qs_pkg::DIV_BITS-1:0]   num_s1, quo_s1;
	logic [SIDE_W-1:0]             side_s1;

	always_comb begin
		nr = {rem_in, num_in[qs_pkg::DIV_BITS-1]};
		ge = nr >= {1'b0, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? qs_pkg::S_W'(nr - {1'b0, den_in}) : nr[qs_pkg::S_W-1:0];
			den_s1  <= den_in;
			num_s1  <= num_in << 1;
			quo_s1  <= {quo_in[qs_pkg::DIV_BITS-2:0], ge};
			side_s1 <= side_in;
		end
	end

	assign valid_out = valid_s1;
	assign rem_out   = rem_s1;
	assign den_out   = den_s1;
	assign num_out   = num_s1;
	assign quo_out   = quo_s1;
	assign side_out  = side_s1;

endmodule

FILE: sv/quaternion_slerp_core.sv
// quaternion slerp core
// input channel: in_valid/in_ready carry two quaternions (signed q2.14 components)
// and the blend fraction (unsigned q1.16, values above one are clamped to one)
// output channel: out_valid/out_ready carry the four blended components and path_taken
// configuration: cfg_wr_en writes the near-opposite threshold from cfg_wr_data, no wait
// throughput: one item per cycle while in_ready is high; every step (dot product,
// 31 square root digits, vectoring and rotation micro-rotations, 47 quotient bits,
// output mix) is its own cell
// items of all three paths flow through the same pipeline and are selected at the end
// reset: pipeline valid bits and out_valid clear, threshold returns to 16
// receiver stall: the result stays in the output register, the pipeline keeps moving
// while its last stage is empty, and freezes (in_ready low) once that stage holds an item
module quaternion_slerp_core #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRACTION_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [14:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] first_w,
	input  logic signed [15:0] first_x,
	input  logic signed [15:0] first_y,
	input  logic signed [15:0] first_z,
	input  logic signed [15:0] second_w,
	input  logic signed [15:0] second_x,
	input  logic signed [15:0] second_y,
	input  logic signed [15:0] second_z,
	input  logic [16:0]        blend,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [1:0]         path_taken
);

	localparam int N       = CORDIC_STAGES;
	localparam int CW      = qs_pkg::CW;
	localparam int S_W     = qs_pkg::S_W;
	localparam int DB      = qs_pkg::DIV_BITS;
	localparam int SQ      = qs_pkg::SQ_STEPS;
	localparam int SH_R    = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
	localparam int SH_L    = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;
	localparam int THR_SH  = 30 - FRACTION_BITS;
	localparam int SQ_SW   = $bits(qs_pkg::sq_side_t);
	localparam int VEC_SW  = $bits(qs_pkg::vec_side_t);
	localparam int ROT_SW  = $bits(qs_pkg::rot_side_t);
	localparam int DIV_SW  = $bits(qs_pkg::div_side_t);
	localparam logic [31:0] GAIN_K = qs_pkg::cordic_gain(CORDIC_STAGES);

	logic        en, ld;
	logic [14:0] threshold_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 15'd16;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// stage 1: capture
	logic        v_s1;
	logic [63:0] qa_s1, qb_s1;
	logic [16:0] t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s1 <= {first_z, first_y, first_x, first_w};
			qb_s1 <= {second_z, second_y, second_x, second_w};
			t_s1  <= (blend > qs_pkg::T_ONE) ? qs_pkg::T_ONE : blend;
		end
	end

	// stage 2: component products
	logic               v_s2;
	logic signed [31:0] prod_s2 [4];
	logic [63:0]        qa_s2, qb_s2;
	logic [16:0]        t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= $signed(qa_s1[16*i +: 16]) * $signed(qb_s1[16*i +: 16]);
			end
			qa_s2 <= qa_s1;
			qb_s2 <= qb_s1;
			t_s2  <= t_s1;
		end
	end

	// stage 3: dot product, magnitude test, rescale to q30
	logic signed [33:0] dot;
	logic [33:0]        mag;
	logic [S_W-1:0]     cmag;
	logic               v_s3;
	logic [63:0]        qa_s3, qb_s3;
	logic [16:0]        t_s3;
	logic               first_s3;
	logic [S_W-1:0]     cmag_s3;
	logic signed [31:0] c_s3;

	always_comb begin
		dot  = 34'(prod_s2[0]) + 34'(prod_s2[1]) + 34'(prod_s2[2]) + 34'(prod_s2[3]);
		mag  = dot[33] ? 34'(-dot) : 34'(dot);
		cmag = S_W'((64'(mag) >> SH_R) << SH_L);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s3    <= qa_s2;
			qb_s3    <= qb_s2;
			t_s3     <= t_s2;
			first_s3 <= (64'(mag) >> (2 * FRACTION_BITS)) != 64'd0;
			cmag_s3  <= cmag;
			c_s3     <= dot[33] ? -$signed(32'(cmag)) : $signed(32'(cmag));
		end
	end

	// stage 4: radicand one minus c squared
	logic                              v_s4;
	logic [qs_pkg::RAD_W-1:0]          rad_s4;
	qs_pkg::sq_side_t                  side_s4;
	logic [61:0]                       csq;

	assign csq = cmag_s3 * cmag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4        <= (62'd1 << 60) - csq;
			side_s4.qa    <= qa_s3;
			side_s4.qb    <= qb_s3;
			side_s4.t     <= t_s3;
			side_s4.first <= first_s3;
			side_s4.c     <= c_s3;
		end
	end

	// square root chain
	logic                           sq_v    [SQ+1];
	logic [qs_pkg::SQ_REM_W-1:0]    sq_rem  [SQ+1];
	logic [S_W-1:0]                 sq_root [SQ+1];
	logic [qs_pkg::RAD_W-1:0]       sq_rad  [SQ+1];
	logic [SQ_SW-1:0]               sq_side [SQ+1];

	assign sq_v[0]    = v_s4;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s4;
	assign sq_side[0] = side_s4;

	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		qs_sqrt_cell #(.SIDE_W(SQ_SW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (sq_v[g]),
			.rem_in    (sq_rem[g]),
			.root_in   (sq_root[g]),
			.rad_in    (sq_rad[g]),
			.side_in   (sq_side[g]),
			.valid_out (sq_v[g+1]),
			.rem_out   (sq_rem[g+1]),
			.root_out  (sq_root[g+1]),
			.rad_out   (sq_rad[g+1]),
			.side_out  (sq_side[g+1])
		);
	end

	// stage 5: path decision and vectoring pre-rotation
	qs_pkg::sq_side_t            sq_end;
	logic [S_W-1:0]              s_end;
	logic [35:0]                 thr_ext;
	logic                        v_s5;
	qs_pkg::vec_side_t           vside_s5;
	logic signed [CW-1:0]        x_s5, y_s5, z_s5;

	assign sq_end  = sq_side[SQ];
	assign s_end   = sq_root[SQ];
	assign thr_ext = 36'(threshold_q) << THR_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vside_s5.qa <= sq_end.qa;
			vside_s5.qb <= sq_end.qb;
			vside_s5.t  <= sq_end.t;
			vside_s5.s  <= s_end;
			if (sq_end.first) begin
				vside_s5.path <= qs_pkg::PATH_FIRST;
			end else if (36'(s_end) < thr_ext) begin
				vside_s5.path <= qs_pkg::PATH_AVG;
			end else begin
				vside_s5.path <= qs_pkg::PATH_SLERP;
			end
			if (sq_end.c[31]) begin
				x_s5 <= $signed(CW'(s_end));
				y_s5 <= -CW'(sq_end.c);
				z_s5 <= $signed(CW'(qs_pkg::HALF_PI));
			end else begin
				x_s5 <= CW'(sq_end.c);
				y_s5 <= $signed(CW'(s_end));
				z_s5 <= '0;
			end
		end
	end

	// vectoring chain: angle of (c, s)
	logic                 vc_v    [N+1];
	logic signed [CW-1:0] vc_x    [N+1];
	logic signed [CW-1:0] vc_y    [N+1];
	logic signed [CW-1:0] vc_z    [N+1];
	logic [VEC_SW-1:0]    vc_side [N+1];

	assign vc_v[0]    = v_s5;
	assign vc_x[0]    = x_s5;
	assign vc_y[0]    = y_s5;
	assign vc_z[0]    = z_s5;
	assign vc_side[0] = vside_s5;

	for (genvar g = 0; g < N; g++) begin : g_vec
		qs_cordic_cell #(.IDX(g), .VECTORING(1'b1), .SIDE_W(VEC_SW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (vc_v[g]),
			.x_in      (vc_x[g]),
			.y_in      (vc_y[g]),
			.z_in      (vc_z[g]),
			.side_in   (vc_side[g]),
			.valid_out (vc_v[g+1]),
			.x_out     (vc_x[g+1]),
			.y_out     (vc_y[g+1]),
			.z_out     (vc_z[g+1]),
			.side_out  (vc_side[g+1])
		);
	end

	// stage 6: clamp angle to [0, pi]
	qs_pkg::vec_side_t vc_end;
	logic              v_s6;
	qs_pkg::vec_side_t vside_s6;
	logic [31:0]       h_s6;

	assign vc_end = vc_side[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= vc_v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vside_s6 <= vc_end;
			if (vc_z[N][CW-1]) begin
				h_s6 <= '0;
			end else if (vc_z[N] > $signed(CW'(qs_pkg::FULL_PI))) begin
				h_s6 <= qs_pkg::FULL_PI;
			end else begin
				h_s6 <= vc_z[N][31:0];
			end
		end
	end

	// stage 7: scale angle by t and one minus t
	logic [48:0]       pha_full, phb_full;
	logic              v_s7;
	qs_pkg::vec_side_t vside_s7;
	logic [31:0]       pha_s7, phb_s7;

	assign pha_full = (qs_pkg::T_ONE - vside_s6.t) * h_s6;
	assign phb_full = vside_s6.t * h_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vside_s7 <= vside_s6;
			pha_s7   <= pha_full[47:16];
			phb_s7   <= phb_full[47:16];
		end
	end

	// stage 8: fold into first quadrant, start rotations
	logic                 v_s8;
	qs_pkg::rot_side_t    rside_s8;
	logic [S_W-1:0]       s_s8;
	logic signed [CW-1:0] za_s8, zb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rside_s8.qa   <= vside_s7.qa;
			rside_s8.qb   <= vside_s7.qb;
			rside_s8.path <= vside_s7.path;
			s_s8          <= vside_s7.s;
			za_s8 <= $signed(CW'((pha_s7 > qs_pkg::HALF_PI) ? qs_pkg::FULL_PI - pha_s7 : pha_s7));
			zb_s8 <= $signed(CW'((phb_s7 > qs_pkg::HALF_PI) ? qs_pkg::FULL_PI - phb_s7 : phb_s7));
		end
	end

	// rotation chains: sine of each scaled angle
	logic                 ra_v [N+1];
	logic signed [CW-1:0] ra_x [N+1];
	logic signed [CW-1:0] ra_y [N+1];
	logic signed [CW-1:0] ra_z [N+1];
	logic [ROT_SW-1:0]    ra_side [N+1];
	logic                 rb_v [N+1];
	logic signed [CW-1:0] rb_x [N+1];
	logic signed [CW-1:0] rb_y [N+1];
	logic signed [CW-1:0] rb_z [N+1];
	logic [S_W-1:0]       rb_side [N+1];

	assign ra_v[0]    = v_s8;
	assign ra_x[0]    = $signed(CW'(GAIN_K));
	assign ra_y[0]    = '0;
	assign ra_z[0]    = za_s8;
	assign ra_side[0] = rside_s8;
	assign rb_v[0]    = v_s8;
	assign rb_x[0]    = $signed(CW'(GAIN_K));
	assign rb_y[0]    = '0;
	assign rb_z[0]    = zb_s8;
	assign rb_side[0] = s_s8;

	for (genvar g = 0; g < N; g++) begin : g_rot
		qs_cordic_cell #(.IDX(g), .VECTORING(1'b0), .SIDE_W(ROT_SW)) u_cell_a (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (ra_v[g]),
			.x_in      (ra_x[g]),
			.y_in      (ra_y[g]),
			.z_in      (ra_z[g]),
			.side_in   (ra_side[g]),
			.valid_out (ra_v[g+1]),
			.x_out     (ra_x[g+1]),
			.y_out     (ra_y[g+1]),
			.z_out     (ra_z[g+1]),
			.side_out  (ra_side[g+1])
		);
		qs_cordic_cell #(.IDX(g), .VECTORING(1'b0), .SIDE_W(S_W)) u_cell_b (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (rb_v[g]),
			.x_in      (rb_x[g]),
			.y_in      (rb_y[g]),
			.z_in      (rb_z[g]),
			.side_in   (rb_side[g]),
			.valid_out (rb_v[g+1]),
			.x_out     (rb_x[g+1]),
			.y_out     (rb_y[g+1]),
			.z_out     (rb_z[g+1]),
			.side_out  (rb_side[g+1])
		);
	end

	// stage 9: clamp sines, set up division by s
	qs_pkg::rot_side_t ra_end;
	logic [31:0]       sin_a, sin_b;
	logic [S_W-1:0]    s_end9;
	logic              v_s9;
	qs_pkg::div_side_t dside_s9;
	logic              ovf_b_s9;
	logic [S_W-1:0]    rema_s9, remb_s9, den_s9;
	logic [DB-1:0]     numa_s9, numb_s9;

	assign ra_end = ra_side[N];
	assign s_end9 = rb_side[N];
	assign sin_a  = ra_y[N][CW-1] ? 32'd0 : ra_y[N][31:0];
	assign sin_b  = rb_y[N][CW-1] ? 32'd0 : rb_y[N][31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= ra_v[N] & rb_v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s9.qa   <= ra_end.qa;
			dside_s9.qb   <= ra_end.qb;
			dside_s9.path <= ra_end.path;
			dside_s9.ovf  <= (sin_a >> 17) >= 32'(s_end9);
			ovf_b_s9      <= (sin_b >> 17) >= 32'(s_end9);
			rema_s9       <= S_W'(sin_a >> 17);
			remb_s9       <= S_W'(sin_b >> 17);
			numa_s9       <= {sin_a[16:0], 30'd0};
			numb_s9       <= {sin_b[16:0], 30'd0};
			den_s9        <= s_end9;
		end
	end

	// divider chains: one quotient bit per cell
	logic              da_v   [DB+1];
	logic [S_W-1:0]    da_rem [DB+1];
	logic [S_W-1:0]    da_den [DB+1];
	logic [DB-1:0]     da_num [DB+1];
	logic [DB-1:0]     da_quo [DB+1];
	logic [DIV_SW-1:0] da_side [DB+1];
	logic              db_v   [DB+1];
	logic [S_W-1:0]    db_rem [DB+1];
	logic [S_W-1:0]    db_den [DB+1];
	logic [DB-1:0]     db_num [DB+1];
	logic [DB-1:0]     db_quo [DB+1];
	logic              db_side [DB+1];

	assign da_v[0]    = v_s9;
	assign da_rem[0]  = rema_s9;
	assign da_den[0]  = den_s9;
	assign da_num[0]  = numa_s9;
	assign da_quo[0]  = '0;
	assign da_side[0] = dside_s9;
	assign db_v[0]    = v_s9;
	assign db_rem[0]  = remb_s9;
	assign db_den[0]  = den_s9;
	assign db_num[0]  = numb_s9;
	assign db_quo[0]  = '0;
	assign db_side[0] = ovf_b_s9;

	for (genvar g = 0; g < DB; g++) begin : g_div
		qs_div_cell #(.SIDE_W(DIV_SW)) u_cell_a (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (da_v[g]),
			.rem_in    (da_rem[g]),
			.den_in    (da_den[g]),
			.num_in    (da_num[g]),
			.quo_in    (da_quo[g]),
			.side_in   (da_side[g]),
			.valid_out (da_v[g+1]),
			.rem_out   (da_rem[g+1]),
			.den_out   (da_den[g+1]),
			.num_out   (da_num[g+1]),
			.quo_out   (da_quo[g+1]),
			.side_out  (da_side[g+1])
		);
		qs_div_cell #(.SIDE_W(1)) u_cell_b (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (db_v[g]),
			.rem_in    (db_rem[g]),
			.den_in    (db_den[g]),
			.num_in    (db_num[g]),
			.quo_in    (db_quo[g]),
			.side_in   (db_side[g]),
			.valid_out (db_v[g+1]),
			.rem_out   (db_rem[g+1]),
			.den_out   (db_den[g+1]),
			.num_out   (db_num[g+1]),
			.quo_out   (db_quo[g+1]),
			.side_out  (db_side[g+1])
		);
	end

	// stage 10: saturate ratios
	qs_pkg::div_side_t da_end;
	logic              v_s10;
	logic [63:0]       qa_s10, qb_s10;
	qs_pkg::path_t     path_s10;
	logic [DB-1:0]     ratio_a_s10, ratio_b_s10;

	assign da_end = da_side[DB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= da_v[DB] & db_v[DB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s10   <= da_end.qa;
			qb_s10   <= da_end.qb;
			path_s10 <= da_end.path;
			ratio_a_s10 <= (da_end.ovf || da_quo[DB] > qs_pkg::RATIO_MAX) ?
				qs_pkg::RATIO_MAX : da_quo[DB];
			ratio_b_s10 <= (db_side[DB] || db_quo[DB] > qs_pkg::RATIO_MAX) ?
				qs_pkg::RATIO_MAX : db_quo[DB];
		end
	end

	// stage 11: weight components
	logic               v_s11;
	logic [63:0]        qa_s11, qb_s11;
	qs_pkg::path_t      path_s11;
	logic signed [63:0] wa_s11 [4];
	logic signed [63:0] wb_s11 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s11   <= qa_s10;
			qb_s11   <= qb_s10;
			path_s11 <= path_s10;
			for (int i = 0; i < 4; i++) begin
				wa_s11[i] <= 64'($signed(qa_s10[16*i +: 16]) * $signed({1'b0, ratio_a_s10}));
				wb_s11[i] <= 64'($signed(qb_s10[16*i +: 16]) * $signed({1'b0, ratio_b_s10}));
			end
		end
	end

	// output register
	logic signed [15:0] res [4];
	logic signed [63:0] mix;
	logic signed [33:0] mix_sh;
	logic signed [16:0] pair_sum;
	logic               out_valid_q;
	logic signed [15:0] res_q [4];
	qs_pkg::path_t      path_q;

	always_comb begin
		mix      = '0;
		mix_sh   = '0;
		pair_sum = '0;
		for (int i = 0; i < 4; i++) begin
			mix      = wa_s11[i] + wb_s11[i] + (64'sd1 <<< 29);
			mix_sh   = 34'(mix >>> 30);
			pair_sum = 17'($signed(qa_s11[16*i +: 16])) + 17'($signed(qb_s11[16*i +: 16]));
			case (path_s11)
				qs_pkg::PATH_FIRST: res[i] = $signed(qa_s11[16*i +: 16]);
				qs_pkg::PATH_AVG:   res[i] = 16'(pair_sum >>> 1);
				default: begin
					if (mix_sh > 34'sd32767) begin
						res[i] = 16'sd32767;
					end else if (mix_sh < -34'sd32768) begin
						res[i] = -16'sd32768;
					end else begin
						res[i] = 16'(mix_sh);
					end
				end
			endcase
		end
	end

	assign ld = ~out_valid_q | out_ready;
	assign en = ld | ~v_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && v_s11) begin
			res_q  <= res;
			path_q <= path_s11;
		end
	end

	assign in_ready   = en;
	assign out_valid  = out_valid_q;
	assign out_w      = res_q[0];
	assign out_x      = res_q[1];
	assign out_y      = res_q[2];
	assign out_z      = res_q[3];
	assign path_taken = path_q;

endmodule

FILE: sv/qs_checker.sv
module qs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_w,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z,
	input logic [1:0]         path_taken
);

	// no result while reset is asserted
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result visible during reset");

	// a free output side never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with free output");

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
			&& $stable(out_y) && $stable(out_z) && $stable(path_taken))
		else $error("stalled item changed");

	// path code in range
	a_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_taken != 2'd3)
		else $error("bad path code");

endmodule

bind quaternion_slerp_core qs_checker u_qs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_w      (out_w),
	.out_x      (out_x),
	.out_y      (out_y),
	.out_z      (out_z),
	.path_taken (path_taken)
);

FILE: tb/sv/tb_quaternion_slerp_core.sv
module tb_quaternion_slerp_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_WAIT = 160;
	localparam int PHASE_ITEMS = 300;

	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		logic [16:0] t;
	} quat_pair_t;

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		qs_pkg::path_t path;
	} blend_res_t;

	typedef struct {
		quat_pair_t q;
		logic [14:0] thr;
		bit known;
		blend_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [14:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] first_w, first_x, first_y, first_z;
	logic signed [15:0] second_w, second_x, second_y, second_z;
	logic [16:0] blend;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] out_w, out_x, out_y, out_z;
	logic [1:0] path_taken;

	quaternion_slerp_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_w(first_w), .first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_w(second_w), .second_x(second_x), .second_y(second_y),
		.second_z(second_z), .blend(blend),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.path_taken(path_taken)
	);

	longint atan_tab[16];
	longint k_gain, pi_half, pi_full;
	logic [14:0] thr_now;
	blend_res_t expected_q[$];
	stim_row_t rows[$];
	int errors = 0;
	int checked = 0;
	int path_count[3] = '{0, 0, 0};
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	longint cycles = 0;

	always #10 clk = ~clk;

	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint unsigned atan_recip(longint unsigned n);
		longint unsigned term, sum, k;
		term = (64'd1 << 62) / n;
		sum = term;
		k = 1;
		forever begin
			term = term / (n * n);
			if (term == 0) break;
			if (k[0]) sum = sum - term / (2 * k + 1);
			else sum = sum + term / (2 * k + 1);
			k++;
		end
		return sum;
	endfunction

	function automatic longint round_q30(longint unsigned v);
		return longint'((v + (64'd1 << 31)) >> 32);
	endfunction

	function automatic void build_tables();
		longint unsigned d;
		atan_tab[0] = round_q30(atan_recip(2) + atan_recip(3));
		for (int i = 1; i < 16; i++) atan_tab[i] = round_q30(atan_recip(64'd1 << i));
		pi_half = 2 * atan_tab[0];
		pi_full = 4 * atan_tab[0];
		k_gain = 64'd1 << 30;
		for (int i = 0; i < 16; i++) begin
			d = sqrt_floor((64'd1 << 60) + ((64'd1 << 60) >> (2 * i)));
			k_gain = longint'((longint'(k_gain) << 30) / d);
		end
	endfunction

	function automatic longint half_angle(longint x, longint y);
		longint z, tmp, xs, ys;
		z = 0;
		if (x < 0) begin
			tmp = x;
			x = y;
			y = -tmp;
			z = pi_half;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_tab[i];
			end else begin
				x -= ys; y += xs; z -= atan_tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > pi_full) z = pi_full;
		return z;
	endfunction

	function automatic longint sine_of(longint phi);
		longint x, y, z, xs, ys;
		x = k_gain;
		y = 0;
		if (phi > pi_half) phi = pi_full - phi;
		z = phi;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_tab[i];
			end else begin
				x += ys; y -= xs; z += atan_tab[i];
			end
		end
		return (y < 0) ? 0 : y;
	endfunction

	function automatic longint weight_of(longint sine, longint s);
		longint unsigned r;
		r = (longint'(sine) << 30) / longint'(s);
		if (r > (64'd1 << 46)) r = 64'd1 << 46;
		return longint'(r);
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic blend_res_t slerp_predict(quat_pair_t q, logic [14:0] thr);
		longint av[4], bv[4], rv[4];
		longint dot, mag, c, s, h, ra, rb, tt, rnd;
		blend_res_t r;
		dot = 0;
		rnd = longint'(1) << 29;
		for (int i = 0; i < 4; i++) begin
			av[i] = $signed(q.a[i]);
			bv[i] = $signed(q.b[i]);
			dot += av[i] * bv[i];
		end
		tt = (q.t > 17'd65536) ? 65536 : q.t;
		mag = (dot < 0) ? -dot : dot;
		if (mag >= (64'd1 << 28)) begin
			for (int i = 0; i < 4; i++) rv[i] = av[i];
			r.path = qs_pkg::PATH_FIRST;
		end else begin
			mag = mag << 2;
			c = (dot < 0) ? -mag : mag;
			s = sqrt_floor((64'd1 << 60) - c * c);
			if (s < (longint'(thr) << 16)) begin
				for (int i = 0; i < 4; i++) rv[i] = (av[i] + bv[i]) >>> 1;
				r.path = qs_pkg::PATH_AVG;
			end else begin
				h = half_angle(c, s);
				ra = weight_of(sine_of(((65536 - tt) * h) >>> 16), s);
				rb = weight_of(sine_of((tt * h) >>> 16), s);
				for (int i = 0; i < 4; i++)
					rv[i] = (av[i] * ra + bv[i] * rb + rnd) >>> 30;
				r.path = qs_pkg::PATH_SLERP;
			end
		end
		r.w = clip16(rv[0]);
		r.x = clip16(rv[1]);
		r.y = clip16(rv[2]);
		r.z = clip16(rv[3]);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_item(quat_pair_t q, bit known, blend_res_t res);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_w <= q.a[0]; first_x <= q.a[1]; first_y <= q.a[2]; first_z <= q.a[3];
		second_w <= q.b[0]; second_x <= q.b[1]; second_y <= q.b[2]; second_z <= q.b[3];
		blend <= q.t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.insert(expected_q.size(), known ? res : slerp_predict(q, thr_now));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_threshold(logic [14:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_now = v;
	endtask

	function automatic quat_pair_t random_pair();
		quat_pair_t q;
		int kind, sel;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			if (kind < 2) begin
				q.a[i] = $urandom;
				q.b[i] = $urandom;
			end else begin
				q.a[i] = 16'($urandom_range(0, 16382) - 8191);
				if (kind < 6) q.b[i] = 16'($urandom_range(0, 16382) - 8191);
				else if (kind < 8) q.b[i] = 16'(-$signed(q.a[i]) + $urandom_range(0, 8) - 4);
				else if (kind == 8) q.b[i] = 16'($signed(q.a[i]) + $urandom_range(0, 8) - 4);
				else q.b[i] = 16'($urandom_range(0, 16382) - 8191);
			end
		end
		if (kind == 9) begin
			sel = $urandom_range(0, 3);
			q.a = '0;
			q.a[sel] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		end
		case ($urandom_range(0, 9))
			0: q.t = 17'd0;
			1: q.t = 17'd65536;
			2: q.t = 17'($urandom_range(65537, 131071));
			default: q.t = 17'($urandom_range(0, 65536));
		endcase
		return q;
	endfunction

	function automatic stim_row_t mk_row(int a0, int a1, int a2, int a3,
			int b0, int b1, int b2, int b3, int t, int thr,
			bit known, int e0, int e1, int e2, int e3, qs_pkg::path_t p);
		stim_row_t r;
		r.q.a = {16'(a3), 16'(a2), 16'(a1), 16'(a0)};
		r.q.b = {16'(b3), 16'(b2), 16'(b1), 16'(b0)};
		r.q.t = 17'(t);
		r.thr = 15'(thr);
		r.known = known;
		r.res.w = 16'(e0); r.res.x = 16'(e1); r.res.y = 16'(e2); r.res.z = 16'(e3);
		r.res.path = p;
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		rows.insert(rows.size(), r);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_reqs != hold_seen) begin
			hold_seen++;
			hold_left = 400;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		blend_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (e.path <= qs_pkg::PATH_SLERP) path_count[e.path]++;
				if (out_w !== e.w) report_mismatch("out_w", out_w, $signed(e.w));
				if (out_x !== e.x) report_mismatch("out_x", out_x, $signed(e.x));
				if (out_y !== e.y) report_mismatch("out_y", out_y, $signed(e.y));
				if (out_z !== e.z) report_mismatch("out_z", out_z, $signed(e.z));
				if (path_taken !== e.path) report_mismatch("path_taken", path_taken, e.path);
			end
		end
	end

	initial begin
		logic [14:0] phase_thr[6];
		blend_res_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{first_w, first_x, first_y, first_z} = '0;
		{second_w, second_x, second_y, second_z} = '0;
		blend = '0;
		none = '0;
		thr_now = 15'd16;
		build_tables();

		// reset threshold first
		add_row(mk_row(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 16, 1,
			16384, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			65536, 16, 1, 32767, 32767, 32767, 32767, qs_pkg::PATH_FIRST));
		add_row(mk_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
			131071, 16, 1, -32768, -32768, -32768, -32768, qs_pkg::PATH_FIRST));
		add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 16, 1,
			0, 0, 0, 0, qs_pkg::PATH_SLERP));
		add_row(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 32768, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 65536, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 65537, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 131071, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(11585, 11585, 0, 0, 11585, -11585, 0, 0, 20000, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, -16383, 1, 0, 0, 32768, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 16383, 0, 0, 0, 1, 16, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		// threshold above one averages every item inside the unit range
		add_row(mk_row(100, 200, -300, 400, 50, -50, 7, -8, 1000, 32767, 1,
			75, 75, -147, 196, qs_pkg::PATH_AVG));
		add_row(mk_row(-1, -1, -1, -1, 0, 0, 0, 0, 0, 32767, 1,
			-1, -1, -1, -1, qs_pkg::PATH_AVG));
		add_row(mk_row(16384, 0, 0, 0, -16383, 0, 0, 0, 32768, 32767, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		// zero threshold disables averaging
		add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 40000, 0, 1,
			0, 0, 0, 0, qs_pkg::PATH_SLERP));
		add_row(mk_row(16384, 0, 0, 0, -16383, 0, 0, 0, 32768, 0, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(16384, 0, 0, 0, 0, 0, 16384, 0, 32768, 0, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));
		add_row(mk_row(-16384, 0, 0, 0, 16383, 0, 0, 0, 16384, 0, 0,
			0, 0, 0, 0, qs_pkg::PATH_FIRST));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 6;
		rx_idle_pct = 63;
		foreach (rows[i]) begin
			if (rows[i].thr != thr_now) begin
				drain();
				write_threshold(rows[i].thr);
			end
			send_item(rows[i].q, rows[i].known, rows[i].res);
		end

		phase_thr = '{15'd0, 15'($urandom_range(0, 2000)), 15'd16384,
			15'd16, 15'd32767, 15'($urandom_range(0, 32767))};
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_threshold(phase_thr[ph]);
			case (ph / 2)
				0: begin tx_idle_pct = 6; rx_idle_pct = 63; end
				1: begin tx_idle_pct = 63; rx_idle_pct = 6; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((ph == 1 || ph == 4) && n == 40) hold_reqs++;
				send_item(random_pair(), 0, none);
			end
		end
		drain();

		$display("checked %0d results: %0d first returned, %0d averaged, %0d slerp",
			checked, path_count[0], path_count[1], path_count[2]);
		$display("six threshold settings, three idle patterns, two long output stalls");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
